FILE: rtl/core/aff_inv_pkg.sv
// Shared types and constants for the affine transform inverse block.
// Request and result structs, lane control struct and fixed datapath widths.
// No dependencies.
package aff_inv_pkg;

    localparam int DATA_W  = 32;
    localparam int LANES   = 12;
    localparam int PROD_W  = 64;
    localparam int CROSS_W = 65;
    localparam int DOT_W   = 97;
    localparam int MAG_W   = 96;
    localparam int D2_W    = 97;

    localparam logic [DATA_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_NEG = 32'h8000_0000;

    // Lane l (row*4 + col) sits at packed index LANES-1-l.
    typedef struct packed {
        logic signed [DATA_W-1:0] in_r0c0;
        logic signed [DATA_W-1:0] in_r0c1;
        logic signed [DATA_W-1:0] in_r0c2;
        logic signed [DATA_W-1:0] in_r0c3;
        logic signed [DATA_W-1:0] in_r1c0;
        logic signed [DATA_W-1:0] in_r1c1;
        logic signed [DATA_W-1:0] in_r1c2;
        logic signed [DATA_W-1:0] in_r1c3;
        logic signed [DATA_W-1:0] in_r2c0;
        logic signed [DATA_W-1:0] in_r2c1;
        logic signed [DATA_W-1:0] in_r2c2;
        logic signed [DATA_W-1:0] in_r2c3;
    } t_in_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] out_r0c0;
        logic signed [DATA_W-1:0] out_r0c1;
        logic signed [DATA_W-1:0] out_r0c2;
        logic signed [DATA_W-1:0] out_r0c3;
        logic signed [DATA_W-1:0] out_r1c0;
        logic signed [DATA_W-1:0] out_r1c1;
        logic signed [DATA_W-1:0] out_r1c2;
        logic signed [DATA_W-1:0] out_r1c3;
        logic signed [DATA_W-1:0] out_r2c0;
        logic signed [DATA_W-1:0] out_r2c1;
        logic signed [DATA_W-1:0] out_r2c2;
        logic signed [DATA_W-1:0] out_r2c3;
    } t_out_req;

    typedef struct packed {
        logic             valid;
        logic             zero;
        logic [LANES-1:0] neg;
    } t_lane_ctl;

endpackage

FILE: rtl/core/aff_inv_front.sv
// Front end: products, cross products, dot products, magnitudes and dividend setup.
// Eight register stages; feeds the divider. Uses aff_inv_pkg.
module aff_inv_front #(
    parameter int FRAC_BITS = 16,
    parameter int NW        = 130
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    input  aff_inv_pkg::t_in_req                       i_req,
    output aff_inv_pkg::t_lane_ctl                     o_ctl,
    output logic [aff_inv_pkg::LANES-1:0][NW-1:0]      o_num,
    output logic [aff_inv_pkg::D2_W-1:0]               o_d2
);

    // cross index: 0 s=a x b, 1 t=c x d, 2 b x c, 3 c x a
    localparam int XP [4] = '{0, 2, 1, 2};
    localparam int XQ [4] = '{1, 3, 2, 0};
    // dot index: 0 det=s.c, 1 b.t, 2 a.t, 3 d.s
    localparam int DX [4] = '{0, 1, 1, 0};
    localparam int DC [4] = '{2, 1, 0, 3};
    localparam int MX [3] = '{2, 3, 0};
    localparam int TD [3] = '{1, 2, 3};
    localparam logic TN [3] = '{1'b1, 1'b0, 1'b1};

    localparam int L = aff_inv_pkg::LANES;

    logic r0_v, r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v;
    aff_inv_pkg::t_in_req r0_req, r1_req, r2_req;

    logic [L-1:0][aff_inv_pkg::DATA_W-1:0] w_v0, w_v2;
    assign w_v0 = r0_req;
    assign w_v2 = r2_req;

    logic signed [aff_inv_pkg::PROD_W-1:0]  n1_p [4][3][2];
    logic signed [aff_inv_pkg::PROD_W-1:0]  r1_p [4][3][2];
    logic signed [aff_inv_pkg::CROSS_W-1:0] n2_x [4][3];
    logic signed [aff_inv_pkg::CROSS_W-1:0] r2_x [4][3];
    logic signed [aff_inv_pkg::CROSS_W-1:0] n3_lo [4][3];
    logic signed [aff_inv_pkg::CROSS_W-1:0] n3_hi [4][3];
    logic signed [aff_inv_pkg::CROSS_W-1:0] r3_lo [4][3];
    logic signed [aff_inv_pkg::CROSS_W-1:0] r3_hi [4][3];
    logic signed [aff_inv_pkg::CROSS_W-1:0] n3_mx [9];
    logic signed [aff_inv_pkg::CROSS_W-1:0] r3_mx [9];
    logic signed [aff_inv_pkg::CROSS_W-1:0] r4_mx [9];
    logic signed [aff_inv_pkg::CROSS_W-1:0] r5_mx [9];
    logic signed [aff_inv_pkg::DOT_W-1:0]   n4_term [4][3];
    logic signed [aff_inv_pkg::DOT_W-1:0]   r4_term [4][3];
    logic signed [aff_inv_pkg::DOT_W-1:0]   n5_dot [4];
    logic signed [aff_inv_pkg::DOT_W-1:0]   r5_dot [4];
    logic [L-1:0][aff_inv_pkg::MAG_W-1:0]   n6_mag, r6_mag;
    logic [L-1:0]                           n6_neg, r6_neg, r7_neg;
    logic [aff_inv_pkg::MAG_W-1:0]          n6_dmag, r6_dmag;
    logic signed [aff_inv_pkg::DOT_W-1:0]   n6_dneg;
    logic                                   r6_zero, r7_zero;
    logic [L-1:0][NW-1:0]                   n7_n, r7_n;
    logic [aff_inv_pkg::D2_W-1:0]           r7_d2;

    genvar x, i, k, m, rw;
    generate
        for (x = 0; x < 4; x++) begin : g_cross
            for (i = 0; i < 3; i++) begin : g_comp
                localparam int J = (i + 1) % 3;
                localparam int K = (i + 2) % 3;
                assign n1_p[x][i][0] =
                    aff_inv_pkg::PROD_W'($signed(w_v0[L-1-(J*4+XP[x])]))
                  * aff_inv_pkg::PROD_W'($signed(w_v0[L-1-(K*4+XQ[x])]));
                assign n1_p[x][i][1] =
                    aff_inv_pkg::PROD_W'($signed(w_v0[L-1-(K*4+XP[x])]))
                  * aff_inv_pkg::PROD_W'($signed(w_v0[L-1-(J*4+XQ[x])]));
                assign n2_x[x][i] = aff_inv_pkg::CROSS_W'(r1_p[x][i][0])
                                  - aff_inv_pkg::CROSS_W'(r1_p[x][i][1]);
            end
        end

        for (k = 0; k < 4; k++) begin : g_dot
            for (i = 0; i < 3; i++) begin : g_term
                logic signed [aff_inv_pkg::CROSS_W-1:0] w_xv;
                logic signed [aff_inv_pkg::DATA_W-1:0]  w_yv;
                assign w_xv = r2_x[DX[k]][i];
                assign w_yv = $signed(w_v2[L-1-(i*4+DC[k])]);
                assign n3_lo[k][i] =
                    aff_inv_pkg::CROSS_W'($signed({1'b0, w_xv[31:0]}))
                  * aff_inv_pkg::CROSS_W'(w_yv);
                assign n3_hi[k][i] =
                    aff_inv_pkg::CROSS_W'($signed(w_xv[aff_inv_pkg::CROSS_W-1:32]))
                  * aff_inv_pkg::CROSS_W'(w_yv);
                assign n4_term[k][i] = (aff_inv_pkg::DOT_W'(r3_hi[k][i]) <<< 32)
                                     + aff_inv_pkg::DOT_W'(r3_lo[k][i]);
            end
            assign n5_dot[k] = r4_term[k][0] + r4_term[k][1] + r4_term[k][2];
        end

        for (rw = 0; rw < 3; rw++) begin : g_row
            for (i = 0; i < 3; i++) begin : g_col
                logic signed [aff_inv_pkg::CROSS_W-1:0] w_abs;
                assign n3_mx[rw*3+i] = r2_x[MX[rw]][i];
                assign w_abs = r5_mx[rw*3+i][aff_inv_pkg::CROSS_W-1]
                             ? -r5_mx[rw*3+i] : r5_mx[rw*3+i];
                assign n6_mag[L-1-(rw*4+i)] = aff_inv_pkg::MAG_W'(w_abs[63:0]);
                assign n6_neg[L-1-(rw*4+i)] = r5_mx[rw*3+i][aff_inv_pkg::CROSS_W-1]
                                            ^ r5_dot[0][aff_inv_pkg::DOT_W-1];
            end
            begin : g_tr
                logic signed [aff_inv_pkg::DOT_W-1:0] w_tv, w_tabs;
                assign w_tv   = r5_dot[TD[rw]];
                assign w_tabs = w_tv[aff_inv_pkg::DOT_W-1] ? -w_tv : w_tv;
                assign n6_mag[L-1-(rw*4+3)] = w_tabs[aff_inv_pkg::MAG_W-1:0];
                assign n6_neg[L-1-(rw*4+3)] = w_tv[aff_inv_pkg::DOT_W-1] ^ TN[rw]
                                            ^ r5_dot[0][aff_inv_pkg::DOT_W-1];
            end
        end

        for (m = 0; m < L; m++) begin : g_num
            localparam int SH = ((m % 4) == 3) ? FRAC_BITS + 1 : 2 * FRAC_BITS + 1;
            assign n7_n[L-1-m] = (NW'(r6_mag[L-1-m]) << SH) + NW'(r6_dmag);
        end
    endgenerate

    assign n6_dneg = -r5_dot[0];
    assign n6_dmag = r5_dot[0][aff_inv_pkg::DOT_W-1] ? n6_dneg[aff_inv_pkg::MAG_W-1:0]
                                                     : r5_dot[0][aff_inv_pkg::MAG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else begin
            r0_v <= i_valid;
            r1_v <= r0_v;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_req  <= i_req;
        r1_req  <= r0_req;
        r2_req  <= r1_req;
        r1_p    <= n1_p;
        r2_x    <= n2_x;
        r3_lo   <= n3_lo;
        r3_hi   <= n3_hi;
        r3_mx   <= n3_mx;
        r4_mx   <= r3_mx;
        r5_mx   <= r4_mx;
        r4_term <= n4_term;
        r5_dot  <= n5_dot;
        r6_mag  <= n6_mag;
        r6_neg  <= n6_neg;
        r6_dmag <= n6_dmag;
        r6_zero <= (r5_dot[0] == '0);
        r7_n    <= n7_n;
        r7_d2   <= {r6_dmag, 1'b0};
        r7_neg  <= r6_neg;
        r7_zero <= r6_zero;
    end

    assign o_ctl = '{valid: r7_v, zero: r7_zero, neg: r7_neg};
    assign o_num = r7_n;
    assign o_d2  = r7_d2;

endmodule

FILE: rtl/core/aff_inv_divider.sv
// Pipelined restoring divider, twelve lanes sharing one divisor, one quotient bit per stage.
// Overflow check stage plus 32 step stages. Uses aff_inv_pkg.
module aff_inv_divider #(
    parameter int NW = 130
) (
    input  logic                                              i_clk,
    input  logic                                              i_rst_n,
    input  aff_inv_pkg::t_lane_ctl                            i_ctl,
    input  logic [aff_inv_pkg::LANES-1:0][NW-1:0]             i_num,
    input  logic [aff_inv_pkg::D2_W-1:0]                      i_d2,
    output aff_inv_pkg::t_lane_ctl                            o_ctl,
    output logic [aff_inv_pkg::LANES-1:0][aff_inv_pkg::DATA_W-1:0] o_q,
    output logic [aff_inv_pkg::LANES-1:0]                     o_ovf
);

    localparam int L  = aff_inv_pkg::LANES;
    localparam int QW = aff_inv_pkg::DATA_W;
    localparam int CW = (NW > aff_inv_pkg::D2_W + QW) ? NW : aff_inv_pkg::D2_W + QW;

    logic                         r_v    [QW+1];
    logic                         r_zero [QW+1];
    logic [L-1:0]                 r_neg  [QW+1];
    logic [L-1:0]                 r_ovf  [QW+1];
    logic [L-1:0][NW-1:0]         r_rem  [QW+1];
    logic [L-1:0][QW-1:0]         r_q    [QW+1];
    logic [aff_inv_pkg::D2_W-1:0] r_d2   [QW+1];

    logic [L-1:0] n_ovf;
    logic [CW-1:0] w_dtop;
    assign w_dtop = CW'(i_d2) << QW;

    genvar g, l;
    generate
        for (l = 0; l < L; l++) begin : g_ovf
            assign n_ovf[l] = CW'(i_num[l]) >= w_dtop;
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_zero[0] <= i_ctl.zero;
        r_neg[0]  <= i_ctl.neg;
        r_ovf[0]  <= n_ovf;
        r_rem[0]  <= i_num;
        r_q[0]    <= '0;
        r_d2[0]   <= i_d2;
    end

    generate
        for (g = 0; g < QW; g++) begin : g_step
            localparam int B = QW - 1 - g;
            logic [CW-1:0]        w_dsh;
            logic [L-1:0][NW-1:0] n_rem;
            logic [L-1:0][QW-1:0] n_q;
            assign w_dsh = CW'(r_d2[g]) << B;
            for (l = 0; l < L; l++) begin : g_lane
                logic          w_take;
                logic [CW-1:0] w_diff;
                assign w_take   = CW'(r_rem[g][l]) >= w_dsh;
                assign w_diff   = CW'(r_rem[g][l]) - w_dsh;
                assign n_rem[l] = w_take ? w_diff[NW-1:0] : r_rem[g][l];
                assign n_q[l]   = {r_q[g][l][QW-2:0], w_take};
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[g+1] <= 1'b0;
                end else begin
                    r_v[g+1] <= r_v[g];
                end
            end

            always_ff @(posedge i_clk) begin
                r_zero[g+1] <= r_zero[g];
                r_neg[g+1]  <= r_neg[g];
                r_ovf[g+1]  <= r_ovf[g];
                r_rem[g+1]  <= n_rem;
                r_q[g+1]    <= n_q;
                r_d2[g+1]   <= r_d2[g];
            end
        end
    endgenerate

    assign o_ctl = '{valid: r_v[QW], zero: r_zero[QW], neg: r_neg[QW]};
    assign o_q   = r_q[QW];
    assign o_ovf = r_ovf[QW];

`ifndef SYNTHESIS
    // remainder must end below the divisor when no overflow was flagged
    a_rem_lane0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[QW] && !r_ovf[QW][0] |-> CW'(r_rem[QW][0]) < CW'(r_d2[QW]))
        else $error("divider remainder out of range, lane 0");
    a_rem_lane3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[QW] && !r_ovf[QW][3] |-> CW'(r_rem[QW][3]) < CW'(r_d2[QW]))
        else $error("divider remainder out of range, lane 3");
`endif

endmodule

FILE: rtl/core/affine_transform_inverse_unit.sv
// Top level of the affine transform inverse block.
// Instantiates aff_inv_front and aff_inv_divider, adds rounding clamp and output register.
// Uses aff_inv_pkg.

// Inverts one 3x4 Q-format affine transform per request. A request is taken on
// any rising edge with start high; busy is always low, so a new request may be
// issued every cycle. Each result appears on o_res with o_valid high for exactly
// one cycle, in request order, after passing through 8 stages
// of multiply, cross/dot product and dividend setup, 33 stages of the shared
// bit-per-stage divider (overflow check plus 32 quotient bits), and the output
// register. Results are rounded to nearest, ties away from zero, and saturate
// to 32 bits; a singular transform returns all zeros. The receiver must take
// every result when it is presented.
module affine_transform_inverse_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  aff_inv_pkg::t_in_req   i_req,
    output logic                   o_valid,
    output aff_inv_pkg::t_out_req  o_res
);

    localparam int NW = ((98 + FRAC_BITS) > (66 + 2 * FRAC_BITS))
                      ? 98 + FRAC_BITS : 66 + 2 * FRAC_BITS;
    localparam int L  = aff_inv_pkg::LANES;
    localparam int QW = aff_inv_pkg::DATA_W;

    aff_inv_pkg::t_lane_ctl       w_fctl, w_dctl;
    logic [L-1:0][NW-1:0]         w_num;
    logic [aff_inv_pkg::D2_W-1:0] w_d2;
    logic [L-1:0][QW-1:0]         w_q;
    logic [L-1:0]                 w_dovf;
    logic [L-1:0][QW-1:0]         n_res;

    logic                  r_valid;
    aff_inv_pkg::t_out_req r_res;

    assign busy = 1'b0;

    aff_inv_front #(
        .FRAC_BITS (FRAC_BITS),
        .NW        (NW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start && !busy),
        .i_req   (i_req),
        .o_ctl   (w_fctl),
        .o_num   (w_num),
        .o_d2    (w_d2)
    );

    aff_inv_divider #(
        .NW (NW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_fctl),
        .i_num   (w_num),
        .i_d2    (w_d2),
        .o_ctl   (w_dctl),
        .o_q     (w_q),
        .o_ovf   (w_dovf)
    );

    genvar l;
    generate
        for (l = 0; l < L; l++) begin : g_lane
            logic [QW-1:0] w_mag, w_lim, w_clip;
            assign w_mag  = w_dovf[l] ? '1 : w_q[l];
            assign w_lim  = w_dctl.neg[l] ? aff_inv_pkg::SAT_NEG : aff_inv_pkg::SAT_POS;
            assign w_clip = (w_mag > w_lim) ? w_lim : w_mag;
            assign n_res[l] = w_dctl.zero ? '0 : (w_dctl.neg[l] ? -w_clip : w_clip);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_dctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

`ifndef SYNTHESIS
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(w_dctl.zero) |-> o_res == '0)
        else $error("singular transform gave nonzero result");
    a_ovf_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(w_dovf[L-1] && !w_dctl.zero) |->
        (o_res.out_r0c0 == aff_inv_pkg::SAT_POS || o_res.out_r0c0 == aff_inv_pkg::SAT_NEG))
        else $error("quotient overflow not saturated");
`endif

endmodule
